// File: src/ttps_pkg.sv
// ttps_pkg: shared types, codes and beat layout for the transposition table
// depends on nothing; used by transposition_table_probe_store

package ttps_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 4096;

    // request kinds on s_tuser
    localparam logic [1:0] REQ_PROBE = 2'd0;
    localparam logic [1:0] REQ_STORE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // bound flags
    localparam logic [1:0] FLAG_EXACT = 2'd0;
    localparam logic [1:0] FLAG_UPPER = 2'd1;
    localparam logic [1:0] FLAG_LOWER = 2'd2;
    localparam logic [1:0] FLAG_NONE  = 2'd3;

    // input beat layout (s_tdata)
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned KEY_LSB   = 0;
    localparam int unsigned DEPTH_LSB = 64;
    localparam int unsigned ALPHA_LSB = 72;
    localparam int unsigned BETA_LSB  = 88;
    localparam int unsigned SCORE_LSB = 104;
    localparam int unsigned FLAG_LSB  = 120;
    localparam int unsigned SQ_LSB    = 122;
    localparam int unsigned PC_LSB    = 130;
    localparam int unsigned S_DATA_W  = 144;
    localparam int unsigned M_DATA_W  = 32;

    // remainder unit: key split into 4-bit digits, each folded through a
    // residue table; three pipeline steps before the slot is known
    localparam int unsigned MOD_DIGIT_W = 4;
    localparam int unsigned MOD_DIGITS  = KEY_W / MOD_DIGIT_W;
    localparam int unsigned MOD_STEPS   = 3;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  depth;
        logic [15:0] score;
        logic [1:0]  flag;
        logic [7:0]  square;
        logic [7:0]  piece;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOD,
        ST_ISSUE,
        ST_SWEEP,
        ST_DONE
    } state_t;

endpackage

// File: src/ttps_ram.sv
// ttps_ram: generic single-port synchronous ram, registered read
// depends on nothing

module ttps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/transposition_table_probe_store.sv
// transposition_table_probe_store: direct-mapped, always-replace transposition table
// depends on ttps_pkg and ttps_ram

// Usage
// - one request beat on s_*: s_tuser carries the kind (probe, store, clear),
//   s_tdata the key, depth, window, score, bound flag and move
// - every request gives exactly one result beat on m_*; store, clear and
//   unknown kinds give an all-zero result
// - slot is key modulo ENTRIES; for a power-of-two ENTRIES it is the low key
//   bits and the table ram is accessed in the accept cycle
// - probe/store do the ram access, then the result load, with a power-of-two
//   ENTRIES; otherwise a residue-table remainder unit adds 3 fold steps, then
//   the ram access, before the result load
// - the result is loaded into the output register in the ST_DONE state, once
//   that register is free
// - clear walks the ram one entry per cycle, then gives its result beat
// - after aresetn the same walk runs with s_tready low
// - a stalled receiver holds the result in the output register; the next
//   request is still taken, its result waiting until the register frees up
// - one request is in flight at a time, so ram accesses never overlap

module transposition_table_probe_store #(
    parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: key[63:0], depth[71:64], alpha[87:72], beta[103:88],
    //          score_in[119:104], bound_flag[121:120], move_square[129:122],
    //          move_piece[137:130], zero pad
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ttps_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: score_out[15:0], best_square[23:16], best_piece[31:24]
    output logic [ttps_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: hit[0], move_valid[1]
    output logic [1:0]                     m_tuser
);

    localparam int unsigned AW       = $clog2(ENTRIES);
    localparam bit          IS_POW2  = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam int unsigned CNT_W    = $clog2(ttps_pkg::MOD_STEPS);
    localparam int unsigned DIG_VALS = 2 ** ttps_pkg::MOD_DIGIT_W;
    localparam int unsigned TAB_W    = ttps_pkg::MOD_DIGITS * DIG_VALS * AW;

    ttps_pkg::state_t state_reg, state_next;

    // request held for the whole access
    logic [1:0]                    req_reg;
    logic [ttps_pkg::S_DATA_W-1:0] in_reg;
    logic [AW-1:0]                 sweep_idx_reg;
    logic                          sweep_last;

    // ram port
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_addr;
    ttps_pkg::entry_t              ram_wdata, ram_rdata;

    // output register
    logic                          m_tvalid_reg;
    logic [ttps_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [1:0]                    m_tuser_reg;
    logic                          out_free, out_load;

    // probe result
    logic                          res_hit, res_mv;
    logic [15:0]                   res_score;
    logic [7:0]                    res_sq, res_pc;

    logic                          in_accept;
    logic [AW-1:0]                 mod_slot;
    logic                          mod_last;

    ttps_pkg::entry_t              blank_entry;

    function automatic ttps_pkg::entry_t entry_from_beat(
        input logic [ttps_pkg::S_DATA_W-1:0] d
    );
        ttps_pkg::entry_t e;
        e.key    = d[ttps_pkg::KEY_LSB   +: 64];
        e.depth  = d[ttps_pkg::DEPTH_LSB +: 8];
        e.score  = d[ttps_pkg::SCORE_LSB +: 16];
        e.flag   = d[ttps_pkg::FLAG_LSB  +: 2];
        e.square = d[ttps_pkg::SQ_LSB    +: 8];
        e.piece  = d[ttps_pkg::PC_LSB    +: 8];
        return e;
    endfunction

    // residue of every digit value at every digit position, modulo ENTRIES
    function automatic logic [TAB_W-1:0] residue_table();
        logic [TAB_W-1:0] t;
        logic [63:0]      w, v;
        t = '0;
        w = 64'd1;
        for (int j = 0; j < ttps_pkg::MOD_DIGITS; j++) begin
            for (int n = 0; n < DIG_VALS; n++) begin
                v = (64'(n) * w) % 64'(ENTRIES);
                t[(j * DIG_VALS + n) * AW +: AW] = v[AW-1:0];
            end
            w = (w * 64'(DIG_VALS)) % 64'(ENTRIES);
        end
        return t;
    endfunction

    assign blank_entry = '{key: '0, depth: '0, score: '0, flag: ttps_pkg::FLAG_NONE,
                           square: '0, piece: '0};

    assign in_accept  = s_tvalid && s_tready;
    assign sweep_last = (sweep_idx_reg == AW'(ENTRIES - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // slot computation
    generate
        if (IS_POW2) begin : g_pow2
            // slot is the low key bits, taken straight from the beat
            assign mod_slot = in_reg[ttps_pkg::KEY_LSB +: AW];
            assign mod_last = 1'b1;
        end else begin : g_mod
            // each key digit looks up its residue; four partial sums, then the
            // total (below 16 * ENTRIES) brought under ENTRIES by four
            // compare-and-subtract steps
            localparam logic [TAB_W-1:0] RES_TAB      = residue_table();
            localparam int unsigned      GROUPS       = 4;
            localparam int unsigned      GROUP_DIGITS = ttps_pkg::MOD_DIGITS / GROUPS;

            logic [AW+1:0]    part_reg  [GROUPS];
            logic [AW+1:0]    part_next [GROUPS];
            logic [AW+3:0]    sum_reg;
            logic [AW-1:0]    rem_reg, rem_next;
            logic [CNT_W-1:0] cnt_reg;

            always_comb begin
                logic [ttps_pkg::MOD_DIGIT_W-1:0] dig;
                for (int g = 0; g < GROUPS; g++) begin
                    part_next[g] = '0;
                    for (int k = 0; k < GROUP_DIGITS; k++) begin
                        dig = in_reg[ttps_pkg::KEY_LSB +
                                     (g * GROUP_DIGITS + k) * ttps_pkg::MOD_DIGIT_W
                                     +: ttps_pkg::MOD_DIGIT_W];
                        part_next[g] = part_next[g] + (AW+2)'(
                            RES_TAB[((g * GROUP_DIGITS + k) * DIG_VALS + int'(dig)) * AW
                                    +: AW]);
                    end
                end
            end

            always_comb begin
                logic [AW+3:0] r;
                r = sum_reg;
                for (int b = 3; b >= 0; b--) begin
                    if (r >= ((AW+4)'(ENTRIES) << b)) begin
                        r = r - ((AW+4)'(ENTRIES) << b);
                    end
                end
                rem_next = r[AW-1:0];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cnt_reg <= '0;
                end else if (in_accept) begin
                    cnt_reg <= '0;
                end else if (state_reg == ttps_pkg::ST_MOD) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end

            // free-running fold pipeline on the held key
            always_ff @(posedge aclk) begin
                for (int g = 0; g < GROUPS; g++) begin
                    part_reg[g] <= part_next[g];
                end
                sum_reg <= (AW+4)'(part_reg[0]) + (AW+4)'(part_reg[1]) +
                           (AW+4)'(part_reg[2]) + (AW+4)'(part_reg[3]);
                rem_reg <= rem_next;
            end

            assign mod_slot = rem_reg;
            assign mod_last = (cnt_reg == CNT_W'(ttps_pkg::MOD_STEPS - 1));
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttps_pkg::ST_INIT: begin
                if (sweep_last) state_next = ttps_pkg::ST_IDLE;
            end
            ttps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        ttps_pkg::REQ_PROBE,
                        ttps_pkg::REQ_STORE: begin
                            state_next = IS_POW2 ? ttps_pkg::ST_DONE : ttps_pkg::ST_MOD;
                        end
                        ttps_pkg::REQ_CLEAR: state_next = ttps_pkg::ST_SWEEP;
                        default:             state_next = ttps_pkg::ST_DONE;
                    endcase
                end
            end
            ttps_pkg::ST_MOD: begin
                if (mod_last) state_next = ttps_pkg::ST_ISSUE;
            end
            ttps_pkg::ST_ISSUE: state_next = ttps_pkg::ST_DONE;
            ttps_pkg::ST_SWEEP: begin
                if (sweep_last) state_next = ttps_pkg::ST_DONE;
            end
            ttps_pkg::ST_DONE: begin
                if (out_free) state_next = ttps_pkg::ST_IDLE;
            end
            default: state_next = ttps_pkg::ST_INIT;
        endcase
    end

    // control outputs and ram port
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = sweep_idx_reg;
        ram_wdata = blank_entry;
        out_load  = 1'b0;
        case (state_reg)
            ttps_pkg::ST_INIT,
            ttps_pkg::ST_SWEEP: begin
                ram_we = 1'b1;
            end
            ttps_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                ram_addr  = s_tdata[ttps_pkg::KEY_LSB +: AW];
                ram_wdata = entry_from_beat(s_tdata);
                ram_we    = IS_POW2 && s_tvalid && (s_tuser == ttps_pkg::REQ_STORE);
                ram_re    = IS_POW2 && s_tvalid && (s_tuser == ttps_pkg::REQ_PROBE);
            end
            ttps_pkg::ST_ISSUE: begin
                ram_addr  = mod_slot;
                ram_wdata = entry_from_beat(in_reg);
                ram_we    = (req_reg == ttps_pkg::REQ_STORE);
                ram_re    = (req_reg == ttps_pkg::REQ_PROBE);
            end
            ttps_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // probe evaluation on the entry read back
    always_comb begin
        logic              key_match, deep_enough;
        logic signed [15:0] s, alpha, beta;
        s           = $signed(ram_rdata.score);
        alpha       = $signed(in_reg[ttps_pkg::ALPHA_LSB +: 16]);
        beta        = $signed(in_reg[ttps_pkg::BETA_LSB +: 16]);
        key_match   = (req_reg == ttps_pkg::REQ_PROBE) &&
                      (ram_rdata.key == in_reg[ttps_pkg::KEY_LSB +: ttps_pkg::KEY_W]);
        deep_enough = (ram_rdata.depth >= in_reg[ttps_pkg::DEPTH_LSB +: 8]);
        res_hit     = 1'b0;
        res_score   = '0;
        if (key_match && deep_enough) begin
            case (ram_rdata.flag)
                ttps_pkg::FLAG_EXACT: begin
                    res_hit   = 1'b1;
                    res_score = s;
                end
                ttps_pkg::FLAG_UPPER: begin
                    if (s <= alpha) begin
                        res_hit   = 1'b1;
                        res_score = alpha;
                    end
                end
                ttps_pkg::FLAG_LOWER: begin
                    if (s >= beta) begin
                        res_hit   = 1'b1;
                        res_score = beta;
                    end
                end
                default: ;
            endcase
        end
        res_mv = key_match;
        res_sq = key_match ? ram_rdata.square : 8'd0;
        res_pc = key_match ? ram_rdata.piece  : 8'd0;
    end

    ttps_ram #(
        .WIDTH (ttps_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ttps_pkg::ST_INIT;
            sweep_idx_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ttps_pkg::ST_INIT || state_reg == ttps_pkg::ST_SWEEP) begin
                // wraps back to zero at the end of the walk
                sweep_idx_reg <= sweep_last ? '0 : sweep_idx_reg + AW'(1);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_reg <= s_tuser;
            in_reg  <= s_tdata;
        end
        if (out_load) begin
            m_tdata_reg <= {res_pc, res_sq, res_score};
            m_tuser_reg <= {res_mv, res_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
